[rtl/gmng_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gmng_pkg;

    // Request opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_EXPAND = 2'd2;
    localparam logic [1:0] OP_COVER  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIAG   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [7:0] COST_AXIS = 8'd100;
    localparam logic [7:0] COST_DIAG = 8'd141;

    localparam logic [2:0] DIR_LAST_AXIS = 3'd3;
    localparam logic [2:0] DIR_LAST_DIAG = 3'd7;

    // Cell checks per direction: destination, then the two corner cells
    localparam logic [1:0] CHK_DEST = 2'd0;
    localparam logic [1:0] CHK_ROW  = 2'd1;
    localparam logic [1:0] CHK_COL  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic       cell_value;
    } gmng_req_t;

    typedef struct packed {
        logic [3:0] from_x;
        logic [3:0] from_y;
        logic [3:0] to_x;
        logic [3:0] to_y;
        logic [7:0] move_cost;
        logic       moves_target;
        logic       none_found;
        logic       last;
    } gmng_res_t;

    typedef struct packed {
        logic [1:0] reg_index;
        logic [4:0] wdata;
    } gmng_cfg_t;

    // Order: +x, -x, +y, -y, (+1,+1), (+1,-1), (-1,+1), (-1,-1)
    function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd4, 3'd5: v = 2'sb01;
            3'd1, 3'd6, 3'd7: v = 2'sb11;
            default:          v = 2'sb00;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd2, 3'd4, 3'd6: v = 2'sb01;
            3'd3, 3'd5, 3'd7: v = 2'sb11;
            default:          v = 2'sb00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/gmng_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface gmng_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/grid_move_neighbor_generator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Grid move lister. Requests arrive on req: write a cell's occupancy, set the
// target cell, expand a cell, or expand from the target ignoring occupancy.
// Expand requests produce one to eight results on res, in order +x, -x, +y,
// -y, then the four diagonals when diagonal mode is on; last marks the final
// result, and a single none_found result is sent when no move is legal.
// cfg writes diagonal mode (index 0), grid width (1) and grid height (2); it
// is always ready and may be written only while the block is idle.
// An expand request reads the occupancy store once per checked cell, each
// read passing through a lookup and an evaluate state: one read per
// direction in axis mode, up to three per diagonal (destination, corners).
// req.ready is low while a request is being expanded, and after reset while
// the occupancy store is cleared one cell a cycle.
// Results sit in an output register; when res stalls, the block keeps
// checking moves until a second legal move has to be handed over, and holds.
module grid_move_neighbor_generator_core #(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    gmng_stream_if.sink    req,
    gmng_stream_if.source  res,
    gmng_stream_if.sink    cfg
);

    import gmng_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    gmng_req_t req_d;
    gmng_cfg_t cfg_d;

    logic [2:0] state_reg, state_next;
    logic [2:0] dir_reg, dir_next;
    logic [1:0] chk_reg, chk_next;
    logic [3:0] fx_reg, fx_next;
    logic [3:0] fy_reg, fy_next;
    logic [3:0] tx_reg, tx_next;
    logic [3:0] ty_reg, ty_next;
    logic       cov_reg, cov_next;
    logic       tgt_reg, tgt_next;
    logic       inb_reg, inb_next;
    logic       pend_valid_reg, pend_valid_next;
    gmng_res_t  pend_reg, pend_next;
    logic       res_valid_reg, res_valid_next;
    gmng_res_t  res_reg, res_next;

    logic       diag_reg;
    logic [4:0] grid_width_reg;
    logic [4:0] grid_height_reg;
    logic [3:0] target_x_reg;
    logic [3:0] target_y_reg;

    logic [6:0] used_w;
    logic [6:0] used_h;
    logic [2:0] dir_last;

    logic signed [1:0] dxv;
    logic signed [1:0] dyv;
    logic signed [5:0] cx;
    logic signed [5:0] cy;
    logic              cell_in;

    logic          req_acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_data;
    logic          clr_busy;

    logic          push_ok;
    logic          cell_ok;
    logic          dir_ok;
    gmng_res_t     cand;

    assign req_d = req.data;
    assign cfg_d = cfg.data;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_acc   = req.valid && req.ready;

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    always_comb
    begin
        if (grid_width_reg == 5'd0)
        begin
            used_w = 7'd1;
        end
        else if ({2'b00, grid_width_reg} > 7'(MAX_WIDTH))
        begin
            used_w = 7'(MAX_WIDTH);
        end
        else
        begin
            used_w = {2'b00, grid_width_reg};
        end

        if (grid_height_reg == 5'd0)
        begin
            used_h = 7'd1;
        end
        else if ({2'b00, grid_height_reg} > 7'(MAX_HEIGHT))
        begin
            used_h = 7'(MAX_HEIGHT);
        end
        else
        begin
            used_h = {2'b00, grid_height_reg};
        end
    end

    assign dir_last = diag_reg ? DIR_LAST_DIAG : DIR_LAST_AXIS;

    // Cell under check: destination, or one of the two corners of a diagonal
    always_comb
    begin
        dxv = dir_dx(dir_reg);
        dyv = dir_dy(dir_reg);
        case (chk_reg)
            CHK_DEST:
            begin
                cx = $signed({2'b00, fx_reg}) + 6'(dxv);
                cy = $signed({2'b00, fy_reg}) + 6'(dyv);
            end
            CHK_ROW:
            begin
                cx = $signed({2'b00, fx_reg}) + 6'(dxv);
                cy = $signed({2'b00, fy_reg});
            end
            default:
            begin
                cx = $signed({2'b00, fx_reg});
                cy = $signed({2'b00, fy_reg}) + 6'(dyv);
            end
        endcase
        cell_in = !cx[5] && !cy[5]
                  && ({2'b00, cx[4:0]} < used_w)
                  && ({2'b00, cy[4:0]} < used_h);
    end

    assign rd_en   = (state_reg == S_LOOK);
    assign rd_addr = AW'(int'(cy[4:0]) * MAX_WIDTH + int'(cx[4:0]));

    assign wr_en   = req_acc && (req_d.opcode == OP_WRITE)
                     && (int'(req_d.pos_x) < MAX_WIDTH)
                     && (int'(req_d.pos_y) < MAX_HEIGHT);
    assign wr_addr = AW'(int'(req_d.pos_y) * MAX_WIDTH + int'(req_d.pos_x));

    gmng_occ_grid #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (req_d.cell_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    assign push_ok = !res_valid_reg || res.ready;
    assign cell_ok = inb_reg && (cov_reg || !rd_data);
    assign dir_ok  = cell_ok && (cov_reg || !dir_reg[2] || (chk_reg == CHK_COL));

    always_comb
    begin
        cand              = '0;
        cand.from_x       = fx_reg;
        cand.from_y       = fy_reg;
        cand.to_x         = tx_reg;
        cand.to_y         = ty_reg;
        cand.move_cost    = dir_reg[2] ? COST_DIAG : COST_AXIS;
        cand.moves_target = tgt_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        chk_next        = chk_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        cov_next        = cov_reg;
        tgt_next        = tgt_reg;
        inb_next        = inb_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_next        = res_reg;

        case (state_reg)
            S_CLEAR:
            begin
                if (!clr_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_acc && (req_d.opcode inside {OP_EXPAND, OP_COVER}))
                begin
                    dir_next = 3'd0;
                    chk_next = CHK_DEST;
                    if (req_d.opcode == OP_COVER)
                    begin
                        fx_next  = target_x_reg;
                        fy_next  = target_y_reg;
                        cov_next = 1'b1;
                        tgt_next = 1'b1;
                    end
                    else
                    begin
                        fx_next  = req_d.pos_x;
                        fy_next  = req_d.pos_y;
                        cov_next = 1'b0;
                        tgt_next = (req_d.pos_x == target_x_reg)
                                   && (req_d.pos_y == target_y_reg);
                    end
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                inb_next = cell_in;
                if (chk_reg == CHK_DEST)
                begin
                    tx_next = cx[3:0];
                    ty_next = cy[3:0];
                end
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cell_ok && !dir_ok)
                begin
                    chk_next   = chk_reg + 2'd1;
                    state_next = S_LOOK;
                end
                else if (!(dir_ok && pend_valid_reg && !push_ok))
                begin
                    // One move held back so the final one can carry last
                    if (dir_ok)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = cand;
                    end
                    if (dir_reg == dir_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        dir_next   = dir_reg + 3'd1;
                        chk_next   = CHK_DEST;
                        state_next = S_LOOK;
                    end
                end
            end
            S_FIN:
            begin
                if (push_ok)
                begin
                    res_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next      = pend_reg;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        res_next            = '0;
                        res_next.none_found = 1'b1;
                        res_next.last       = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            dir_reg         <= '0;
            chk_reg         <= CHK_DEST;
            pend_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
            diag_reg        <= 1'b0;
            grid_width_reg  <= 5'd16;
            grid_height_reg <= 5'd16;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            dir_reg        <= dir_next;
            chk_reg        <= chk_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_d.reg_index)
                    CFG_DIAG:   diag_reg        <= cfg_d.wdata[0];
                    CFG_WIDTH:  grid_width_reg  <= cfg_d.wdata;
                    CFG_HEIGHT: grid_height_reg <= cfg_d.wdata;
                    default:    ;
                endcase
            end
            if (req_acc && req_d.opcode == OP_TARGET)
            begin
                target_x_reg <= req_d.pos_x;
                target_y_reg <= req_d.pos_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        cov_reg  <= cov_next;
        tgt_reg  <= tgt_next;
        inb_reg  <= inb_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

[rtl/gmng_occ_grid.sv]
`timescale 1ns / 1ps
`default_nettype none

module gmng_occ_grid #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data,
    output logic               clr_busy
);

    logic          mem [DEPTH];
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic          rd_data_reg;

    // Clearing pass after reset, one cell a cycle
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire
